### design/ihq_pkg.sv
// Shared types and codes of the indexed min-heap queue.
`timescale 1ns / 1ps
`default_nettype none
package ihq_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int KEY_BITS_DEF  = 32;
  localparam int ITEM_BITS_DEF = 16;
  localparam int MAX_NOTES     = 32;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_POP      = 2'd1;
  localparam logic [1:0] OP_DECREASE = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_BAD_POS   = 2'd3;

  typedef logic [15:0] item_out_t;
  typedef logic [9:0]  pos_out_t;
  typedef logic [10:0] cnt_out_t;

  // One notice pushed by the sequencer.
  typedef struct packed {
    logic      valid;
    item_out_t item;
    pos_out_t  pos;
    logic      removed;
  } note_t;

  // End-of-operation summary shared by all results of one item.
  typedef struct packed {
    logic      done;
    item_out_t front;
    cnt_out_t  count;
    logic [1:0] status;
  } summary_t;

endpackage
`default_nettype wire

### design/ihq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ihq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### design/ihq_notes.sv
// Notice buffer: collect notices of one operation, then hand them out as results.
`timescale 1ns / 1ps
`default_nettype none
module ihq_notes (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ihq_pkg::note_t    push_i,
  input  wire ihq_pkg::summary_t sum_i,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   notice_valid_o,
  output logic [15:0]            notice_item_o,
  output logic [9:0]             notice_position_o,
  output logic                   notice_removed_o,
  output logic [15:0]            front_item_o,
  output logic [10:0]            heap_count_o,
  output logic [1:0]             status_o,
  output logic                   last_o
);

  localparam int IdxW = $clog2(ihq_pkg::MAX_NOTES);

  ihq_pkg::item_out_t buf_item [ihq_pkg::MAX_NOTES];
  ihq_pkg::pos_out_t  buf_pos  [ihq_pkg::MAX_NOTES];
  logic               buf_rem  [ihq_pkg::MAX_NOTES];

  logic [IdxW:0]      wr_q, wr_d;
  logic [IdxW-1:0]    rd_q, rd_d;
  logic               drain_q, drain_d;
  ihq_pkg::summary_t  sum_q;
  logic               has_notes;
  logic               fire;

  assign has_notes = (wr_q != '0);
  assign fire      = drain_q && out_ready_i;
  assign last_o    = !has_notes || ({1'b0, rd_q} == wr_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (push_i.valid && !drain_q && (wr_q < (IdxW+1)'(ihq_pkg::MAX_NOTES))) begin
      buf_item[wr_q[IdxW-1:0]] <= push_i.item;
      buf_pos[wr_q[IdxW-1:0]]  <= push_i.pos;
      buf_rem[wr_q[IdxW-1:0]]  <= push_i.removed;
    end
    if (sum_i.done) begin
      sum_q <= sum_i;
    end
  end

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    drain_d = drain_q;
    if (push_i.valid && !drain_q && (wr_q < (IdxW+1)'(ihq_pkg::MAX_NOTES))) begin
      wr_d = wr_q + 1'b1;
    end
    if (sum_i.done) begin
      drain_d = 1'b1;
    end
    if (fire) begin
      if (last_o) begin
        drain_d = 1'b0;
        wr_d    = '0;
        rd_d    = '0;
      end else begin
        rd_d = rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      drain_q <= 1'b0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      drain_q <= drain_d;
    end
  end

  assign busy_o            = drain_q;
  assign out_valid_o       = drain_q;
  assign notice_valid_o    = has_notes;
  assign notice_item_o     = has_notes ? buf_item[rd_q] : '0;
  assign notice_position_o = (has_notes && !buf_rem[rd_q]) ? buf_pos[rd_q] : '0;
  assign notice_removed_o  = has_notes && buf_rem[rd_q];
  assign front_item_o      = sum_q.front;
  assign heap_count_o      = sum_q.count;
  assign status_o          = sum_q.status;

endmodule
`default_nettype wire

### design/ihq_ctrl.sv
// Heap sequencer: swim and sink steps around one shared key comparator.
`timescale 1ns / 1ps
`default_nettype none
module ihq_ctrl #(
  parameter int CAPACITY  = ihq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS  = ihq_pkg::KEY_BITS_DEF,
  parameter int ITEM_BITS = ihq_pkg::ITEM_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [1:0]                  op_i,
  input  wire logic [15:0]                 item_index_i,
  input  wire logic [31:0]                 item_key_i,
  input  wire logic [9:0]                  heap_position_i,
  output logic                             idle_o,
  output logic                             we_o,
  output logic [$clog2(CAPACITY)-1:0]      waddr_o,
  output logic [ITEM_BITS+KEY_BITS-1:0]    wdata_o,
  output logic [$clog2(CAPACITY)-1:0]      raddr_o,
  input  wire logic [ITEM_BITS+KEY_BITS-1:0] rdata_i,
  output ihq_pkg::note_t                   push_o,
  output ihq_pkg::summary_t                sum_o
);

  localparam int PosW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DEC_RD   = 15'b000000000000010,
    S_SWIM     = 15'b000000000000100,
    S_SWIM_CMP = 15'b000000000001000,
    S_SWIM_WR2 = 15'b000000000010000,
    S_POP_RA   = 15'b000000000100000,
    S_POP_RB   = 15'b000000001000000,
    S_POP_WR2  = 15'b000000010000000,
    S_SINK     = 15'b000000100000000,
    S_SINK_L   = 15'b000001000000000,
    S_SINK_R   = 15'b000010000000000,
    S_SINK_CMP = 15'b000100000000000,
    S_SINK_WR2 = 15'b001000000000000,
    S_REMOVE   = 15'b010000000000000,
    S_FRONT    = 15'b100000000000000
  } state_e;

  state_e                state_q, state_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [PosW-1:0]       pos_q, pos_d, par_q, par_d, ch_q, ch_d;
  logic [ITEM_BITS-1:0]  cur_item_q, cur_item_d, b_item_q, b_item_d, a_item_q, a_item_d;
  logic [KEY_BITS-1:0]   cur_key_q, cur_key_d, b_key_q, b_key_d, a_key_q, a_key_d;
  logic [1:0]            status_q, status_d;

  logic [ITEM_BITS-1:0]  rd_item;
  logic [KEY_BITS-1:0]   rd_key;
  logic [ITEM_BITS-1:0]  in_item;
  logic [KEY_BITS-1:0]   in_key;
  logic [PosW:0]         ch_w;
  logic [KEY_BITS-1:0]   cmp_a, cmp_b;
  logic                  cmp_gt;
  logic                  note_en, note_rem;
  logic [ITEM_BITS-1:0]  note_item;
  logic [PosW-1:0]       note_pos;

  assign rd_item = rdata_i[ITEM_BITS+KEY_BITS-1:KEY_BITS];
  assign rd_key  = rdata_i[KEY_BITS-1:0];
  assign in_item = ITEM_BITS'(item_index_i);
  assign in_key  = KEY_BITS'(item_key_i);
  assign ch_w    = {pos_q, 1'b1};

  // Shared key comparator: operands picked per step.
  always_comb begin
    cmp_a = cur_key_q;
    cmp_b = b_key_q;
    case (state_q)
      S_SWIM_CMP: begin
        cmp_a = rd_key;
        cmp_b = cur_key_q;
      end
      S_SINK_R: begin
        cmp_a = b_key_q;
        cmp_b = rd_key;
      end
      default: begin
        cmp_a = cur_key_q;
        cmp_b = b_key_q;
      end
    endcase
  end
  assign cmp_gt = (cmp_a > cmp_b);

  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    par_d      = par_q;
    ch_d       = ch_q;
    cur_item_d = cur_item_q;
    cur_key_d  = cur_key_q;
    b_item_d   = b_item_q;
    b_key_d    = b_key_q;
    a_item_d   = a_item_q;
    a_key_d    = a_key_q;
    status_d   = status_q;
    we_o       = 1'b0;
    waddr_o    = pos_q;
    wdata_o    = {cur_item_q, cur_key_q};
    raddr_o    = '0;
    note_en    = 1'b0;
    note_rem   = 1'b0;
    note_item  = cur_item_q;
    note_pos   = pos_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          status_d = ihq_pkg::ST_OK;
          state_d  = S_FRONT;
          if (op_i == ihq_pkg::OP_INSERT) begin
            if (cnt_q == CntW'(CAPACITY)) begin
              status_d = ihq_pkg::ST_FULL;
            end else begin
              we_o       = 1'b1;
              waddr_o    = PosW'(cnt_q);
              wdata_o    = {in_item, in_key};
              note_en    = 1'b1;
              note_item  = in_item;
              note_pos   = PosW'(cnt_q);
              cur_item_d = in_item;
              cur_key_d  = in_key;
              pos_d      = PosW'(cnt_q);
              cnt_d      = cnt_q + 1'b1;
              state_d    = S_SWIM;
            end
          end else if (op_i == ihq_pkg::OP_POP) begin
            if (cnt_q == '0) begin
              status_d = ihq_pkg::ST_EMPTY;
            end else begin
              raddr_o = '0;
              state_d = S_POP_RA;
            end
          end else if (op_i == ihq_pkg::OP_DECREASE) begin
            if (32'(heap_position_i) >= 32'(cnt_q)) begin
              status_d = ihq_pkg::ST_BAD_POS;
            end else begin
              raddr_o   = PosW'(heap_position_i);
              pos_d     = PosW'(heap_position_i);
              cur_key_d = in_key;
              state_d   = S_DEC_RD;
            end
          end
        end
      end
      S_DEC_RD: begin
        // Rewrite the key in place; no notice for a key change.
        cur_item_d = rd_item;
        we_o       = 1'b1;
        waddr_o    = pos_q;
        wdata_o    = {rd_item, cur_key_q};
        state_d    = S_SWIM;
      end
      S_SWIM: begin
        if (pos_q == '0) begin
          state_d = S_FRONT;
        end else begin
          par_d   = PosW'((pos_q - 1'b1) >> 1);
          raddr_o = PosW'((pos_q - 1'b1) >> 1);
          state_d = S_SWIM_CMP;
        end
      end
      S_SWIM_CMP: begin
        if (cmp_gt) begin
          b_item_d  = rd_item;
          b_key_d   = rd_key;
          we_o      = 1'b1;
          waddr_o   = par_q;
          wdata_o   = {cur_item_q, cur_key_q};
          note_en   = 1'b1;
          note_item = cur_item_q;
          note_pos  = par_q;
          state_d   = S_SWIM_WR2;
        end else begin
          state_d = S_FRONT;
        end
      end
      S_SWIM_WR2: begin
        we_o      = 1'b1;
        waddr_o   = pos_q;
        wdata_o   = {b_item_q, b_key_q};
        note_en   = 1'b1;
        note_item = b_item_q;
        note_pos  = pos_q;
        pos_d     = par_q;
        state_d   = S_SWIM;
      end
      S_POP_RA: begin
        a_item_d = rd_item;
        a_key_d  = rd_key;
        raddr_o  = PosW'(cnt_q - 1'b1);
        state_d  = S_POP_RB;
      end
      S_POP_RB: begin
        b_item_d  = rd_item;
        b_key_d   = rd_key;
        we_o      = 1'b1;
        waddr_o   = '0;
        wdata_o   = rdata_i;
        note_en   = 1'b1;
        note_item = rd_item;
        note_pos  = '0;
        state_d   = S_POP_WR2;
      end
      S_POP_WR2: begin
        we_o       = 1'b1;
        waddr_o    = PosW'(cnt_q - 1'b1);
        wdata_o    = {a_item_q, a_key_q};
        note_en    = 1'b1;
        note_item  = a_item_q;
        note_pos   = PosW'(cnt_q - 1'b1);
        cnt_d      = cnt_q - 1'b1;
        cur_item_d = b_item_q;
        cur_key_d  = b_key_q;
        pos_d      = '0;
        state_d    = (cnt_q == CntW'(1)) ? S_REMOVE : S_SINK;
      end
      S_SINK: begin
        if (32'(ch_w) >= 32'(cnt_q)) begin
          state_d = S_REMOVE;
        end else begin
          ch_d    = PosW'(ch_w);
          raddr_o = PosW'(ch_w);
          state_d = S_SINK_L;
        end
      end
      S_SINK_L: begin
        b_item_d = rd_item;
        b_key_d  = rd_key;
        if (32'(ch_q) + 32'd1 < 32'(cnt_q)) begin
          raddr_o = ch_q + 1'b1;
          state_d = S_SINK_R;
        end else begin
          state_d = S_SINK_CMP;
        end
      end
      S_SINK_R: begin
        // Take the right child only if the left key is strictly greater.
        if (cmp_gt) begin
          b_item_d = rd_item;
          b_key_d  = rd_key;
          ch_d     = ch_q + 1'b1;
        end
        state_d = S_SINK_CMP;
      end
      S_SINK_CMP: begin
        if (cmp_gt) begin
          we_o      = 1'b1;
          waddr_o   = pos_q;
          wdata_o   = {b_item_q, b_key_q};
          note_en   = 1'b1;
          note_item = b_item_q;
          note_pos  = pos_q;
          state_d   = S_SINK_WR2;
        end else begin
          state_d = S_REMOVE;
        end
      end
      S_SINK_WR2: begin
        we_o      = 1'b1;
        waddr_o   = ch_q;
        wdata_o   = {cur_item_q, cur_key_q};
        note_en   = 1'b1;
        note_item = cur_item_q;
        note_pos  = ch_q;
        pos_d     = ch_q;
        state_d   = S_SINK;
      end
      S_REMOVE: begin
        note_en   = 1'b1;
        note_rem  = 1'b1;
        note_item = a_item_q;
        note_pos  = '0;
        state_d   = S_FRONT;
      end
      S_FRONT: begin
        // Fetch the root; the summary goes out next cycle.
        raddr_o = '0;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    par_q      <= par_d;
    ch_q       <= ch_d;
    cur_item_q <= cur_item_d;
    cur_key_q  <= cur_key_d;
    b_item_q   <= b_item_d;
    b_key_q    <= b_key_d;
    a_item_q   <= a_item_d;
    a_key_q    <= a_key_d;
    status_q   <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  assign idle_o = (state_q == S_IDLE) && !done_q;

  assign push_o.valid   = note_en;
  assign push_o.item    = ihq_pkg::item_out_t'(note_item);
  assign push_o.pos     = ihq_pkg::pos_out_t'(note_pos);
  assign push_o.removed = note_rem;

  assign sum_o.done   = done_q;
  assign sum_o.front  = (cnt_q != '0) ? ihq_pkg::item_out_t'(rd_item) : '0;
  assign sum_o.count  = ihq_pkg::cnt_out_t'(cnt_q);
  assign sum_o.status = status_q;

endmodule
`default_nettype wire

### design/indexed_min_heap_queue_core.sv
// Top level of the indexed min-heap queue: sequencer, slot RAM and notice buffer.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o  | op, item_index, item_key, heap_position
//   out     | output    | out_valid_o / out_ready_i| notice fields, front_item, heap_count,
//           |           |                         | status, last
//
// One item at a time. Insert writes the new slot and swims it up, each swap a
// parent read, a compare and two slot writes; pop swaps the root and the last
// slot, shrinks the count and sinks the new root, reading the left and then the
// right child at each level; a key change reads the slot, rewrites its key and
// swims like an insert. The first result follows in the cycle after the summary.
// The single-port-read slot RAM (one read per cycle, registered) paces these
// steps. Results then drain one per cycle while out_ready_i is high. Reset
// clears the heap count, the sequencer state and the notice buffer; the slot
// RAM needs no clearing, since only slots below the count are ever used.
// in_ready_o stays low from acceptance until the last result of that item is taken.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_queue_core #(
  parameter int CAPACITY  = ihq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS  = ihq_pkg::KEY_BITS_DEF,
  parameter int ITEM_BITS = ihq_pkg::ITEM_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] item_index_i,
  input  wire logic [31:0] item_key_i,
  input  wire logic [9:0]  heap_position_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             notice_valid_o,
  output logic [15:0]      notice_item_o,
  output logic [9:0]       notice_position_o,
  output logic             notice_removed_o,
  output logic [15:0]      front_item_o,
  output logic [10:0]      heap_count_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  localparam int PosW  = $clog2(CAPACITY);
  localparam int SlotW = ITEM_BITS + KEY_BITS;

  logic              ctrl_idle;
  logic              notes_busy;
  logic              start;
  logic              ram_we;
  logic [PosW-1:0]   ram_waddr;
  logic [PosW-1:0]   ram_raddr;
  logic [SlotW-1:0]  ram_wdata;
  logic [SlotW-1:0]  ram_rdata;
  ihq_pkg::note_t    push;
  ihq_pkg::summary_t summary;

  // Take a new item only when the sequencer rests and every result has left.
  assign in_ready_o = ctrl_idle && !notes_busy;
  assign start      = in_valid_i && in_ready_o;

  ihq_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .ITEM_BITS (ITEM_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .op_i            (op_i),
    .item_index_i    (item_index_i),
    .item_key_i      (item_key_i),
    .heap_position_i (heap_position_i),
    .idle_o          (ctrl_idle),
    .we_o            (ram_we),
    .waddr_o         (ram_waddr),
    .wdata_o         (ram_wdata),
    .raddr_o         (ram_raddr),
    .rdata_i         (ram_rdata),
    .push_o          (push),
    .sum_o           (summary)
  );

  // Item and key of each slot share one word.
  ihq_ram #(
    .WIDTH (SlotW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold notices until the root is known, then drain them.
  ihq_notes u_notes (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .sum_i             (summary),
    .busy_o            (notes_busy),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .notice_valid_o    (notice_valid_o),
    .notice_item_o     (notice_item_o),
    .notice_position_o (notice_position_o),
    .notice_removed_o  (notice_removed_o),
    .front_item_o      (front_item_o),
    .heap_count_o      (heap_count_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input accepted while results pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !in_ready_o)
    else $error("ready right after accepting an item");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(heap_count_o) <= CAPACITY))
    else $error("heap count above capacity");

  a_removed_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && notice_removed_o) |-> last_o)
    else $error("removal notice not the final result");

  a_error_no_notice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ihq_pkg::ST_OK)) |-> (!notice_valid_o && last_o))
    else $error("error status with notices");
`endif

endmodule
`default_nettype wire

### verif/indexed_min_heap_queue_core_tb.sv
// Self-checking testbench for the indexed min-heap queue core.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_queue_core_tb;

  localparam int CAP = 1024;
  localparam int WATCHDOG_LIMIT = 20000;

  // One operation waiting to be driven.
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] item;
    logic [31:0] key;
    logic [9:0]  pos;
    logic        drain;  // hold off until every expected result has arrived
  } heap_op_t;

  // One expected result.
  typedef struct packed {
    logic        nvalid;
    logic [15:0] nitem;
    logic [9:0]  npos;
    logic        nremoved;
    logic [15:0] front;
    logic [10:0] count;
    logic [1:0]  status;
    logic        last;
  } heap_note_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = ihq_pkg::OP_INSERT;
  logic [15:0] item_index_i = '0;
  logic [31:0] item_key_i = '0;
  logic [9:0] heap_position_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic notice_valid_o;
  logic [15:0] notice_item_o;
  logic [9:0] notice_position_o;
  logic notice_removed_o;
  logic [15:0] front_item_o;
  logic [10:0] heap_count_o;
  logic [1:0] status_o;
  logic last_o;

  indexed_min_heap_queue_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .item_index_i, .item_key_i,
    .heap_position_i, .out_valid_o, .out_ready_i, .notice_valid_o, .notice_item_o,
    .notice_position_o, .notice_removed_o, .front_item_o, .heap_count_o, .status_o,
    .last_o
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: a private copy of the heap.
  logic [15:0] shadow_items[CAP];
  logic [31:0] shadow_keys[CAP];
  int          shadow_count;

  heap_op_t   pending_ops[$];
  heap_note_t expected_notes[$];
  heap_note_t staged_notes[$];

  int  mismatches = 0;
  int  ops_sent = 0;
  int  notes_seen = 0;
  bit  stimulus_done = 0;
  bit  timed_out = 0;
  int  idle_cycles = 0;

  // Record a slot write as a notice.
  task automatic write_slot(input int p, input logic [15:0] it, input logic [31:0] k);
    heap_note_t n;
    shadow_items[p] = it;
    shadow_keys[p] = k;
    n = '0;
    n.nvalid = 1'b1;
    n.nitem = it;
    n.npos = p[9:0];
    staged_notes.push_back(n);
  endtask

  task automatic swap_slots(input int a, input int b);
    logic [15:0] ia, ib;
    logic [31:0] ka, kb;
    ia = shadow_items[a]; ka = shadow_keys[a];
    ib = shadow_items[b]; kb = shadow_keys[b];
    write_slot(a, ib, kb);
    write_slot(b, ia, ka);
  endtask

  task automatic swim(input int p);
    int par;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (!(shadow_keys[par] > shadow_keys[p])) break;
      swap_slots(par, p);
      p = par;
    end
  endtask

  task automatic sink(input int p);
    int ch;
    forever begin
      ch = 2 * p + 1;
      if (ch >= shadow_count) break;
      if (ch + 1 < shadow_count && shadow_keys[ch] > shadow_keys[ch + 1]) ch = ch + 1;
      if (!(shadow_keys[p] > shadow_keys[ch])) break;
      swap_slots(p, ch);
      p = ch;
    end
  endtask

  // Apply one operation to the shadow heap and queue its expected results.
  task automatic predict_heap_op(input heap_op_t t);
    logic [1:0]  st;
    logic [15:0] popped;
    heap_note_t  n;
    st = ihq_pkg::ST_OK;
    staged_notes.delete();
    case (t.op)
      ihq_pkg::OP_INSERT: begin
        if (shadow_count >= CAP) st = ihq_pkg::ST_FULL;
        else begin
          shadow_count++;
          write_slot(shadow_count - 1, t.item, t.key);
          swim(shadow_count - 1);
        end
      end
      ihq_pkg::OP_POP: begin
        if (shadow_count == 0) st = ihq_pkg::ST_EMPTY;
        else begin
          popped = shadow_items[0];
          swap_slots(0, shadow_count - 1);
          shadow_count--;
          if (shadow_count > 0) sink(0);
          n = '0;
          n.nvalid = 1'b1;
          n.nitem = popped;
          n.nremoved = 1'b1;
          staged_notes.push_back(n);
        end
      end
      ihq_pkg::OP_DECREASE: begin
        if (t.pos >= shadow_count) st = ihq_pkg::ST_BAD_POS;
        else begin
          shadow_keys[t.pos] = t.key;
          swim(t.pos);
        end
      end
      default: ;
    endcase
    if (staged_notes.size() == 0) staged_notes.push_back('0);
    foreach (staged_notes[i]) begin
      n = staged_notes[i];
      n.front = shadow_count > 0 ? shadow_items[0] : 16'd0;
      n.count = shadow_count[10:0];
      n.status = st;
      n.last = (i == staged_notes.size() - 1);
      expected_notes.push_back(n);
    end
  endtask

  function automatic heap_op_t make_op(input logic [1:0] op, input logic [15:0] it,
                                       input logic [31:0] k, input logic [9:0] p);
    heap_op_t t;
    t.op = op; t.item = it; t.key = k; t.pos = p; t.drain = 1'b0;
    return t;
  endfunction

  // Acceptance flags of the last rising edge, one per channel.
  logic in_ready_q = 1'b0;
  logic out_taken_q = 1'b0;
  int   out_wait = 0;

  // Driver: present one operation at a time after a random gap.
  int  send_gap = 0;
  bit  waiting_drain = 0;
  always @(negedge clk_i) begin
    heap_op_t t;
    int w;
    if (rst_ni) begin
      if (in_valid_i && !in_ready_q) begin
        // hold the current item
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_ops.size() > 0) begin
        t = pending_ops[0];
        if (t.drain && expected_notes.size() != 0) begin
          in_valid_i <= 1'b0;
        end else begin
          t = pending_ops.pop_front();
          op_i <= t.op; item_index_i <= t.item; item_key_i <= t.key;
          heap_position_i <= t.pos;
          in_valid_i <= 1'b1;
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        end
      end else begin
        in_valid_i <= 1'b0;
        stimulus_done <= 1'b1;
      end
      // Draw a fresh wait after each taken result, then hold ready low for it.
      if (out_taken_q) begin
        w = $urandom_range(0, 3);
        out_wait <= w;
        out_ready_i <= (w == 0);
      end else if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_ready_i <= (out_wait == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: predict on accepted items and check each taken result.
  always @(posedge clk_i) begin
    heap_op_t t;
    heap_note_t e;
    in_ready_q <= in_valid_i && in_ready_o;
    out_taken_q <= out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        t = make_op(op_i, item_index_i, item_key_i, heap_position_i);
        predict_heap_op(t);
        ops_sent++;
      end
      if (out_valid_o && out_ready_i) begin
        notes_seen++;
        if (expected_notes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: item %0d", notice_item_o);
        end else begin
          e = expected_notes.pop_front();
          if (e.nvalid !== notice_valid_o || e.nitem !== notice_item_o ||
              e.npos !== notice_position_o || e.nremoved !== notice_removed_o ||
              e.front !== front_item_o || e.count !== heap_count_o ||
              e.status !== status_o || e.last !== last_o) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp v%0d i%0d p%0d r%0d f%0d c%0d s%0d l%0d",
                e.nvalid, e.nitem, e.npos, e.nremoved, e.front, e.count, e.status,
                e.last);
              $display("          got v%0d i%0d p%0d r%0d f%0d c%0d s%0d l%0d",
                notice_valid_o, notice_item_o, notice_position_o, notice_removed_o,
                front_item_o, heap_count_o, status_o, last_o);
            end
          end
        end
      end
      // Watchdog on cycles with no accepted item on either side.
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
    end
  end

  initial begin
    int n_rand;
    int r;
    shadow_count = 0;
    // Directed: empty pop, bad position, extremes, ties, single-entry pop.
    pending_ops.push_back(make_op(ihq_pkg::OP_POP, 16'h0, 32'h0, 10'd0));
    pending_ops.push_back(make_op(ihq_pkg::OP_DECREASE, 16'h0, 32'h0, 10'd0));
    pending_ops.push_back(make_op(ihq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 10'h3FF));
    pending_ops.push_back(make_op(ihq_pkg::OP_POP, 16'h0, 32'h0, 10'd0));
    pending_ops.push_back(make_op(ihq_pkg::OP_INSERT, 16'h0001, 32'd50, 10'd0));
    pending_ops.push_back(make_op(ihq_pkg::OP_INSERT, 16'h0002, 32'd50, 10'd0));
    pending_ops.push_back(make_op(ihq_pkg::OP_INSERT, 16'h0003, 32'd40, 10'd0));
    pending_ops.push_back(make_op(ihq_pkg::OP_INSERT, 16'h0000, 32'd0, 10'd0));
    pending_ops.push_back(make_op(ihq_pkg::OP_INSERT, 16'hAAAA, 32'hFFFF_FFFF, 10'd0));
    pending_ops.push_back(make_op(ihq_pkg::OP_DECREASE, 16'h0, 32'd0, 10'd4));
    pending_ops.push_back(make_op(ihq_pkg::OP_DECREASE, 16'h0, 32'hFFFF_FFFF, 10'd1));
    pending_ops.push_back(make_op(ihq_pkg::OP_DECREASE, 16'h0, 32'd1, 10'h3FF));
    pending_ops.push_back(make_op(ihq_pkg::OP_UNUSED, 16'h5555, 32'h1234, 10'd7));
    for (int i = 0; i < 6; i++) begin
      pending_ops.push_back(make_op(ihq_pkg::OP_POP, 16'h0, 32'h0, 10'd0));
    end
    pending_ops[pending_ops.size() - 1].drain = 1'b1;
    // Random mix, biased toward inserts so the heap grows deep; keys from small
    // ranges give ties, full range exercises every bit.
    n_rand = 270;
    for (int i = 0; i < n_rand; i++) begin
      heap_op_t t;
      r = $urandom_range(0, 9);
      t = make_op(r < 5 ? ihq_pkg::OP_INSERT :
                  (r < 7 ? ihq_pkg::OP_POP :
                  (r < 9 ? ihq_pkg::OP_DECREASE : ihq_pkg::OP_UNUSED)),
                  16'($urandom), $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15),
                  $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 40)));
      if (i == 130) t.drain = 1'b1;
      pending_ops.push_back(t);
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (timed_out || (stimulus_done && expected_notes.size() == 0));
    repeat (50) @(posedge clk_i);
    $display("Covered %0d operations and %0d results, %0d mismatches.",
             ops_sent, notes_seen, mismatches);
    if (timed_out) begin
      $display("[indexed_min_heap_queue_core] ERROR");
      $finish;
    end else begin
      if (mismatches == 0 && expected_notes.size() == 0)
        $display("[indexed_min_heap_queue_core] OK");
      else
        $display("[indexed_min_heap_queue_core] ERROR");
      $finish;
    end
  end

endmodule
`default_nettype wire
